[rtl/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/vgn_pkg.sv]
// types and constants of the vector gradient normalizer
// no dependencies
package vgn_pkg;

    localparam int COMP_W_DEF = 32;
    localparam int GAIN_W     = 24;
    localparam int GAIN_FRAC  = 16;
    localparam int NSQ_W      = 64;
    localparam int ROOT_W     = 32;
    localparam int SIGMA_W    = 40;
    localparam int DEN_W      = 41;
    localparam int QUO_W      = 32;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_MEASURE = 2'd1,
        CMD_NORM    = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t               cmd;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } item_t;

endpackage

[rtl/vgn_front.sv]
// front end: accepts words, sign-extends components, drops unused commands
// and queues the rest in a two-entry queue; uses vgn_pkg
module vgn_front #(
    parameter int COMP_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [95:0]   s_tdata,
    input  logic [1:0]    s_tuser,
    output logic          q_valid,
    input  logic          q_ready,
    output vgn_pkg::item_t q_item
);
    import vgn_pkg::*;

    localparam int SH = 32 - COMP_WIDTH;

    item_t       mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push, pop;
    item_t       in_item;
    logic signed [31:0] tx, ty, tz;

    assign s_tready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        tx = $signed(s_tdata[31:0] << SH);
        ty = $signed(s_tdata[63:32] << SH);
        tz = $signed(s_tdata[95:64] << SH);
        in_item.cmd = cmd_t'(s_tuser);
        in_item.x   = tx >>> SH;
        in_item.y   = ty >>> SH;
        in_item.z   = tz >>> SH;
    end

    assign push = s_tvalid && s_tready && (cmd_t'(s_tuser) != CMD_NONE);
    assign pop  = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_item;
    end

endmodule

[rtl/vgn_back.sv]
// back end: squared norm, maximum tracking, two square roots, sigma,
// three restoring dividers and saturation into the output register; uses vgn_pkg
module vgn_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  vgn_pkg::item_t              q_item,
    input  logic [vgn_pkg::GAIN_W-1:0]  gain,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [95:0]                 m_tdata,
    output logic                        m_tuser
);
    import vgn_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_SQ    = 8'b0000_0010,
        ST_EVAL  = 8'b0000_0100,
        ST_SQRT  = 8'b0000_1000,
        ST_SIGMA = 8'b0001_0000,
        ST_DSUM  = 8'b0010_0000,
        ST_DIV   = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    cmd_t   cmd_reg;
    logic [1:0]  sq_cnt_reg;
    logic [4:0]  it_cnt_reg;
    logic [31:0] mag_reg [3];
    logic        neg_reg [3];
    logic [NSQ_W-1:0] acc_reg;
    logic [NSQ_W-1:0] max_reg;

    logic [NSQ_W-1:0]  rad_reg [2];
    logic [ROOT_W+1:0] srem_reg [2];
    logic [ROOT_W-1:0] root_reg [2];
    logic [SIGMA_W-1:0] sigma_reg;
    logic [DEN_W-1:0]   den_reg;

    logic [DEN_W-1:0] drem_reg [3];
    logic [31:0]      lo_reg [3];
    logic [QUO_W-1:0] quo_reg [3];
    logic             ovf_reg [3];

    logic        out_valid_reg;
    logic [95:0] out_data_reg;
    logic        out_zero_reg;
    logic        out_free;

    logic [31:0] sq_op;
    logic [63:0] sq_prod;
    logic [GAIN_W+ROOT_W-1:0] sig_prod;
    logic [31:0] res [3];

    function automatic logic [31:0] mag_of(input logic signed [31:0] v);
        mag_of = v[31] ? 32'(-v) : 32'(v);
    endfunction

    assign out_free = !out_valid_reg || m_tready;
    assign q_ready  = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_zero_reg;

    always_comb
    begin
        case (sq_cnt_reg)
            2'd0:    sq_op = mag_reg[0];
            2'd1:    sq_op = mag_reg[1];
            default: sq_op = mag_reg[2];
        endcase
        sq_prod  = sq_op * sq_op;
        sig_prod = gain * root_reg[1];
        for (int i = 0; i < 3; i++)
        begin
            if (neg_reg[i])
                res[i] = (ovf_reg[i] || (quo_reg[i] > 32'h8000_0000)) ? 32'h8000_0000
                                                                       : 32'(-quo_reg[i]);
            else
                res[i] = (ovf_reg[i] || quo_reg[i][31]) ? 32'h7fff_ffff : quo_reg[i];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (q_valid && q_item.cmd != CMD_CLEAR) state_next = ST_SQ;
            ST_SQ:    if (sq_cnt_reg == 2'd2) state_next = ST_EVAL;
            ST_EVAL:
            begin
                if (cmd_reg != CMD_NORM)
                    state_next = ST_IDLE;
                else if (acc_reg == '0)
                    state_next = ST_OUT;
                else
                    state_next = ST_SQRT;
            end
            ST_SQRT:  if (it_cnt_reg == 5'd31) state_next = ST_SIGMA;
            ST_SIGMA: state_next = ST_DSUM;
            ST_DSUM:  state_next = ST_DIV;
            ST_DIV:   if (it_cnt_reg == 5'd31) state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
            sq_cnt_reg    <= '0;
            it_cnt_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    sq_cnt_reg <= '0;
                    if (q_valid && q_item.cmd == CMD_CLEAR)
                        max_reg <= '0;
                end
                ST_SQ:   sq_cnt_reg <= sq_cnt_reg + 2'd1;
                ST_EVAL:
                begin
                    it_cnt_reg <= '0;
                    if (cmd_reg == CMD_MEASURE && acc_reg > max_reg)
                        max_reg <= acc_reg;
                end
                ST_SQRT: it_cnt_reg <= it_cnt_reg + 5'd1;
                ST_DSUM: it_cnt_reg <= '0;
                ST_DIV:  it_cnt_reg <= it_cnt_reg + 5'd1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                cmd_reg    <= q_item.cmd;
                mag_reg[0] <= mag_of(q_item.x);
                mag_reg[1] <= mag_of(q_item.y);
                mag_reg[2] <= mag_of(q_item.z);
                neg_reg[0] <= q_item.x[31];
                neg_reg[1] <= q_item.y[31];
                neg_reg[2] <= q_item.z[31];
                acc_reg    <= '0;
            end
            ST_SQ: acc_reg <= acc_reg + sq_prod;
            ST_EVAL:
            begin
                rad_reg[0] <= acc_reg;
                rad_reg[1] <= max_reg;
                for (int k = 0; k < 2; k++)
                begin
                    srem_reg[k] <= '0;
                    root_reg[k] <= '0;
                end
                for (int i = 0; i < 3; i++)
                begin
                    quo_reg[i] <= '0;
                    ovf_reg[i] <= 1'b0;
                end
            end
            ST_SQRT:
            begin
                for (int k = 0; k < 2; k++)
                begin
                    logic [ROOT_W+3:0] remsh;
                    logic [ROOT_W+3:0] trial;
                    remsh = {srem_reg[k], rad_reg[k][NSQ_W-1 -: 2]};
                    trial = {2'b00, root_reg[k], 2'b01};
                    rad_reg[k] <= {rad_reg[k][NSQ_W-3:0], 2'b00};
                    if (remsh >= trial)
                    begin
                        srem_reg[k] <= (ROOT_W+2)'(remsh - trial);
                        root_reg[k] <= {root_reg[k][ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        srem_reg[k] <= (ROOT_W+2)'(remsh);
                        root_reg[k] <= {root_reg[k][ROOT_W-2:0], 1'b0};
                    end
                end
            end
            ST_SIGMA: sigma_reg <= SIGMA_W'(sig_prod >> GAIN_FRAC);
            ST_DSUM:
            begin
                logic [DEN_W-1:0] d;
                d = DEN_W'(root_reg[0]) + DEN_W'(sigma_reg);
                den_reg <= d;
                for (int i = 0; i < 3; i++)
                begin
                    drem_reg[i] <= DEN_W'(mag_reg[i] >> 2);
                    lo_reg[i]   <= {mag_reg[i][1:0], 30'd0};
                    ovf_reg[i]  <= (DEN_W'(mag_reg[i] >> 2) >= d);
                end
            end
            ST_DIV:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    logic [DEN_W:0] remsh;
                    remsh = {drem_reg[i], lo_reg[i][31]};
                    lo_reg[i] <= {lo_reg[i][30:0], 1'b0};
                    if (remsh >= {1'b0, den_reg})
                    begin
                        drem_reg[i] <= DEN_W'(remsh - {1'b0, den_reg});
                        quo_reg[i]  <= {quo_reg[i][QUO_W-2:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg[i] <= DEN_W'(remsh);
                        quo_reg[i]  <= {quo_reg[i][QUO_W-2:0], 1'b0};
                    end
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    if (acc_reg == '0)
                    begin
                        out_data_reg <= '0;
                        out_zero_reg <= 1'b1;
                    end
                    else
                    begin
                        out_data_reg <= {res[2], res[1], res[0]};
                        out_zero_reg <= 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

[rtl/vector_gradient_normalizer_top.sv]
// normalize word: from input acceptance to m_tvalid it passes the queue, squaring,
// evaluate, square root, sigma, sum, divide and output, in that order (a zero vector goes
// from evaluate straight to output); back end takes a new word only once it is idle again,
// and a normalize word also waits on m_tready for the output; a two-entry queue buffers input
// reset clears the stored maximum, the gain register, queue and output valid
module vector_gradient_normalizer_top #(
    parameter int COMP_WIDTH = vgn_pkg::COMP_W_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // comp_x, comp_y, comp_z
    input  logic [1:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // norm_x, norm_y, norm_z
    output logic        m_tuser    // was_zero
);
    import vgn_pkg::*;

    localparam logic [2:0] ADDR_GAIN = 3'd0;

    logic [GAIN_W-1:0] gain_reg;
    logic              q_valid, q_ready;
    item_t             q_item;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_GAIN) ? {{(32-GAIN_W){1'b0}}, gain_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gain_reg <= '0;
        else if (psel && penable && pwrite && pready && paddr == ADDR_GAIN)
            gain_reg <= pwdata[GAIN_W-1:0];
    end

    vgn_front #(.COMP_WIDTH(COMP_WIDTH)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    vgn_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .gain    (gain_reg),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

[rtl/vgn_checker.sv]
// port-level checks of the vector gradient normalizer, bound to the top level
// uses assert_macros.svh
`include "assert_macros.svh"

module vgn_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        pready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic        m_tuser
);

    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

    logic signed [31:0] out_x;

    assign out_x = m_tdata[31:0];

    `ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "output word dropped")
    `ASSERT_CLK(a_zero_data, m_tvalid && m_tuser |-> m_tdata == 96'd0, "zero vector not zero")
    `ASSERT_ALWAYS(a_pready, pready, "pready low")
    `ASSERT_CLK(a_x_bound, m_tvalid |-> out_x <= ONE_Q30 && out_x >= -ONE_Q30, "x above one")

endmodule

bind vector_gradient_normalizer_top vgn_checker u_vgn_checker (.*);

[sim/vector_gradient_normalizer_top_tb.sv]
// testbench of vector_gradient_normalizer_top: clear, measure, normalize and unused words
// with random bursts and receiver stalls, checked against an in-bench predictor
// depends on rtl/vgn_pkg.sv and rtl/vector_gradient_normalizer_top.sv
module vector_gradient_normalizer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import vgn_pkg::*;

    typedef struct packed {
        logic [31:0] nx;
        logic [31:0] ny;
        logic [31:0] nz;
        logic        zero;
    } norm_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;   // comp_x, comp_y, comp_z
    logic [1:0]  s_tuser = '0;   // cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;        // norm_x, norm_y, norm_z
    logic        m_tuser;        // was_zero

    item_t       pending_words[$];
    norm_res_t   expected_norms[$];
    logic [63:0] peak_norm_sq = '0;
    logic [23:0] gain = '0;
    int          errors = 0;
    int          checked = 0;
    int          zeros_seen = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          hold_cycles = 0;
    bit          stall_pattern_on = 1'b1;
    bit          in_taken = 1'b0;

    vector_gradient_normalizer_top uut (.*);

    always #5 clk = ~clk;

    function automatic logic [63:0] isqrt64(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res = '0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] mag32(input logic [31:0] c);
        return c[31] ? 64'(-$signed({32'hffffffff, c})) : {32'd0, c};
    endfunction

    function automatic logic [31:0] scale_comp(input logic [31:0] c, input logic [63:0] d);
        logic [127:0] q;
        q = ({64'd0, mag32(c)} << 30) / {64'd0, d};
        if (c[31])
        begin
            if (q > 128'h80000000)
                q = 128'h80000000;
            return 32'(-q[31:0]);
        end
        if (q > 128'h7fffffff)
            q = 128'h7fffffff;
        return q[31:0];
    endfunction

    function automatic void predict_norm(input item_t w);
        logic [63:0] nsq;
        logic [63:0] den;
        norm_res_t   r;
        if (w.cmd == CMD_CLEAR)
        begin
            peak_norm_sq = '0;
            return;
        end
        if (w.cmd == CMD_NONE)
            return;
        nsq = mag32(w.x) * mag32(w.x) + mag32(w.y) * mag32(w.y) + mag32(w.z) * mag32(w.z);
        if (w.cmd == CMD_MEASURE)
        begin
            if (nsq > peak_norm_sq)
                peak_norm_sq = nsq;
            return;
        end
        if (nsq == 0)
            r = '{32'd0, 32'd0, 32'd0, 1'b1};
        else
        begin
            den = isqrt64(nsq) + (({40'd0, gain} * isqrt64(peak_norm_sq)) >> GAIN_FRAC);
            r = '{scale_comp(w.x, den), scale_comp(w.y, den), scale_comp(w.z, den), 1'b0};
        end
        expected_norms = {expected_norms, r};
    endfunction

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || in_taken)
            begin
                if (pending_words.size() > 0 && burst_left > 0)
                begin
                    item_t w;
                    w = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= w.cmd;
                    s_tdata <= {w.z, w.y, w.x};
                    burst_left <= burst_left - 1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                    if (gap_left > 0)
                        gap_left <= gap_left - 1;
                    else
                    begin
                        burst_left <= $urandom_range(1, 20);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
                    end
                end
            end
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles <= hold_cycles - 1;
            end
            else if (stall_pattern_on)
                m_tready <= ($urandom_range(0, 3) != 0);
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        in_taken = rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            item_t w;
            w.cmd = cmd_t'(s_tuser);
            w.x = s_tdata[31:0];
            w.y = s_tdata[63:32];
            w.z = s_tdata[95:64];
            predict_norm(w);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            norm_res_t got;
            norm_res_t exp_r;
            got = '{m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser};
            if (expected_norms.size() == 0)
            begin
                $display("%0t unexpected word: expected none actual %h", $time, got);
                errors++;
            end
            else
            begin
                exp_r = expected_norms.pop_front();
                checked++;
                if (got.zero)
                    zeros_seen++;
                if (got.nx !== exp_r.nx)
                    $display("%0t norm_x: expected %h actual %h", $time, exp_r.nx, got.nx);
                if (got.ny !== exp_r.ny)
                    $display("%0t norm_y: expected %h actual %h", $time, exp_r.ny, got.ny);
                if (got.nz !== exp_r.nz)
                    $display("%0t norm_z: expected %h actual %h", $time, exp_r.nz, got.nz);
                if (got.zero !== exp_r.zero)
                    $display("%0t was_zero: expected %b actual %b", $time, exp_r.zero,
                             got.zero);
                if (got !== exp_r)
                    errors++;
            end
        end
    end

    task automatic write_gain(input logic [23:0] v);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= {8'd0, v};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        gain = v;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_drained;
        while (pending_words.size() > 0 || s_tvalid || expected_norms.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 7))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'(int'($urandom_range(0, 20)) - 10);
            3: return 32'(int'($urandom_range(0, 2000000)) - 1000000);
            4: return 32'd0;
            default: return $urandom();
        endcase
    endfunction

    task automatic add_word(input cmd_t c, input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
        item_t w;
        w = '{c, x, y, z};
        pending_words = {pending_words, w};
    endtask

    task automatic add_random(input int n);
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 15);
            if (k == 0)
                add_word(CMD_CLEAR, $urandom(), $urandom(), $urandom());
            else if (k == 1)
                add_word(CMD_NONE, $urandom(), $urandom(), $urandom());
            else if (k < 7)
                add_word(CMD_MEASURE, rand_comp(), rand_comp(), rand_comp());
            else
                add_word(CMD_NORM, rand_comp(), rand_comp(), rand_comp());
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        write_gain(24'd0);
        add_word(CMD_NORM, 32'h00010000, 32'd0, 32'd0);
        add_word(CMD_NORM, 32'd0, 32'd0, 32'd0);
        add_word(CMD_MEASURE, 32'h80000000, 32'h80000000, 32'h80000000);
        add_word(CMD_NORM, 32'h7fffffff, 32'h80000000, 32'd1);
        add_word(CMD_NORM, 32'hffffffff, 32'd1, 32'hffffffff);
        add_word(CMD_NONE, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        add_word(CMD_MEASURE, 32'd0, 32'd0, 32'd0);
        add_word(CMD_CLEAR, 32'd5, 32'd6, 32'd7);
        add_word(CMD_NORM, 32'h80000000, 32'd0, 32'd0);
        wait_drained();
        write_gain(24'hffffff);
        add_word(CMD_MEASURE, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        add_word(CMD_NORM, 32'd1, 32'hffffffff, 32'd0);
        add_word(CMD_NORM, 32'h80000000, 32'h7fffffff, 32'h12345678);
        add_word(CMD_NORM, 32'd0, 32'd0, 32'd0);
        add_random(300);
        wait_drained();
        write_gain(24'h010000);
        hold_cycles = 600;
        add_random(700);
        wait_drained();
        write_gain(24'(($urandom() & 24'hffffff)));
        add_random(500);
        wait_drained();
        write_gain(24'h000001);
        stall_pattern_on = 1'b0;
        add_random(500);
        wait_drained();
        $display("checked %0d normalized words, %0d of them zero vectors, gain set 5 times",
                 checked, zeros_seen);
        if (errors == 0)
            $display("vector_gradient_normalizer_top: match");
        else
            $display("vector_gradient_normalizer_top: mismatch");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("vector_gradient_normalizer_top: mismatch");
        $finish;
    end
endmodule
